@@ src/graphic_eq_peaking_biquad_cascade_assert.svh @@
// assertion macros for the checker file
`ifndef GRAPHIC_EQ_PEAKING_BIQUAD_CASCADE_ASSERT_SVH
`define GRAPHIC_EQ_PEAKING_BIQUAD_CASCADE_ASSERT_SVH

// same-cycle implication
`define GEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("geq assertion failed");

// next-cycle implication
`define GEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("geq assertion failed");

`endif

@@ src/geq_pkg.sv @@
package geq_pkg;

   localparam int NUM_BANDS      = 10;
   localparam int NUM_CHANNELS   = 2;
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 26;
   localparam int COEF_FRAC_BITS = 22;
   localparam int CFG_BITS       = 10;
   localparam int BAND_BITS      = 4;
   localparam int SEL_BITS       = 2;
   localparam int COEFS_PER_BAND = 4;

   localparam int BAND_IDX_BITS  = $clog2(NUM_BANDS);
   localparam int BAND_CNT_BITS  = $clog2(NUM_BANDS + 1);
   localparam int HIST_ROWS      = NUM_CHANNELS * NUM_BANDS;
   localparam int HIST_ADDR_BITS = $clog2(HIST_ROWS);
   localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS       = PROD_BITS + 3;
   localparam int SHIFT_BITS     = ACC_BITS - COEF_FRAC_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_LOAD   = 1'b1;

   localparam logic [SEL_BITS-1:0] COEF_B0 = 2'd0;
   localparam logic [SEL_BITS-1:0] COEF_B1 = 2'd1;
   localparam logic [SEL_BITS-1:0] COEF_B2 = 2'd2;
   localparam logic [SEL_BITS-1:0] COEF_A2 = 2'd3;

   localparam coef_type   COEF_ONE   = coef_type'(64'sd1 <<< COEF_FRAC_BITS);
   localparam acc_type    ROUND_HALF = acc_type'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      STEP_B0_X,
      STEP_B1_X1,
      STEP_B2_X2,
      STEP_A1_Y1,
      STEP_A2_Y2
   } mac_step_type;

   typedef struct packed {
      sample_type x1;
      sample_type x2;
      sample_type y1;
      sample_type y2;
   } hist_row_type;

   typedef struct packed {
      logic                     start;
      logic                     coef_wr;
      logic                     rd_en;
      logic [BAND_IDX_BITS-1:0] rd_band;
      logic                     mul_en;
      mac_step_type             step;
      logic                     acc_clear;
      logic                     band_done;
      logic                     out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

   function automatic logic band_bypassed(logic [CFG_BITS-1:0] mask,
                                          logic [BAND_CNT_BITS-1:0] band);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
         if (i < CFG_BITS && band == BAND_CNT_BITS'(i)) begin
            hit = mask[i];
         end
      end
      return hit;
   endfunction

endpackage

@@ src/geq_req_if.sv @@
interface geq_req_if;
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic                             channel;
   logic [geq_pkg::BAND_BITS-1:0]    band;
   logic [geq_pkg::SEL_BITS-1:0]     coef_select;
   geq_pkg::coef_type                coef_value;
   geq_pkg::sample_type              sample_in;

   modport source (output valid, mode, channel, band, coef_select, coef_value, sample_in,
                   input ready);
   modport sink (input valid, mode, channel, band, coef_select, coef_value, sample_in,
                 output ready);
endinterface

@@ src/geq_rsp_if.sv @@
interface geq_rsp_if;
   logic                valid;
   logic                ready;
   geq_pkg::sample_type sample_out;
   logic                channel_out;
   logic                clipped;

   modport source (output valid, sample_out, channel_out, clipped, input ready);
   modport sink (input valid, sample_out, channel_out, clipped, output ready);
endinterface

@@ src/geq_ctrl.sv @@
module geq_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_mode,
   input  logic [geq_pkg::BAND_BITS-1:0]    req_band,
   output logic                             req_ready,
   input  logic                             csr_wr_en,
   input  logic [geq_pkg::CFG_BITS-1:0]     csr_wr_data,
   input  geq_pkg::dp_status_type           status,
   output geq_pkg::dp_cmd_type              cmd
);
   import geq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [BAND_CNT_BITS-1:0] band_ff;
   mac_step_type             step_ff;
   logic [CFG_BITS-1:0]      bypass_ff;

   logic accept;
   logic bands_done;
   logic skip_band;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign bands_done = (band_ff == BAND_CNT_BITS'(NUM_BANDS));
   assign skip_band  = band_bypassed(bypass_ff, band_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         band_ff   <= '0;
         step_ff   <= STEP_B0_X;
         bypass_ff <= '1;
      end else begin
         if (csr_wr_en) begin
            bypass_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_mode == MODE_SAMPLE) begin
                  band_ff  <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (bands_done) begin
                  state_ff <= ST_FINISH;
               end else if (skip_band) begin
                  band_ff <= band_ff + 1'b1;
               end else begin
                  step_ff  <= STEP_B0_X;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               step_ff <= mac_step_type'(3'(step_ff + 3'd1));
               if (step_ff == STEP_A2_Y2) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               band_ff  <= band_ff + 1'b1;
               state_ff <= ST_SCAN;
            end
            ST_FINISH: begin
               if (!status.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.start     = (state_ff == ST_IDLE) && accept && req_mode == MODE_SAMPLE;
      cmd.coef_wr   = (state_ff == ST_IDLE) && accept && req_mode == MODE_LOAD
                      && (req_band < BAND_BITS'(NUM_BANDS));
      cmd.rd_en     = (state_ff == ST_SCAN) && !bands_done && !skip_band;
      cmd.acc_clear = cmd.rd_en;
      cmd.rd_band   = band_ff[BAND_IDX_BITS-1:0];
      cmd.mul_en    = (state_ff == ST_MAC);
      cmd.step      = step_ff;
      cmd.band_done = (state_ff == ST_ROUND);
      cmd.out_load  = (state_ff == ST_FINISH) && !status.out_busy;
   end

endmodule

@@ src/geq_dp.sv @@
module geq_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  geq_pkg::dp_cmd_type            cmd,
   output geq_pkg::dp_status_type         status,
   input  logic                           req_channel,
   input  logic [geq_pkg::BAND_BITS-1:0]  req_band,
   input  logic [geq_pkg::SEL_BITS-1:0]   req_coef_select,
   input  geq_pkg::coef_type              req_coef_value,
   input  geq_pkg::sample_type            req_sample_in,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output geq_pkg::sample_type            rsp_sample_out,
   output logic                           rsp_channel_out,
   output logic                           rsp_clipped
);
   import geq_pkg::*;

   // coefficient and history stores, valid bits stand in for the reset values
   coef_type                                coef_mem [NUM_BANDS][COEFS_PER_BAND];
   logic [NUM_BANDS-1:0][COEFS_PER_BAND-1:0] coef_vld_ff;
   coef_type                                coef_row_ff [COEFS_PER_BAND];
   logic [COEFS_PER_BAND-1:0]               coef_row_vld_ff;

   hist_row_type                hist_mem [HIST_ROWS];
   logic [HIST_ROWS-1:0]        hist_vld_ff;
   hist_row_type                hist_row_ff;
   logic                        hist_row_vld_ff;
   logic [HIST_ADDR_BITS-1:0]   hist_addr_ff;

   sample_type x_ff;
   logic       ch_ff;
   logic       clip_ff;

   prod_type prod_ff;
   logic     prod_sub_ff;
   logic     prod_vld_ff;
   acc_type  acc_ff;

   logic       rsp_valid_ff;
   sample_type rsp_sample_ff;
   logic       rsp_channel_ff;
   logic       rsp_clipped_ff;

   logic [HIST_ADDR_BITS-1:0] rd_addr;
   coef_type                  coef_eff [COEFS_PER_BAND];
   hist_row_type              hist_eff;
   coef_type                  op_c;
   sample_type                op_s;
   logic                      op_sub;
   prod_type                  mul;
   acc_type                   rnd;
   logic signed [SHIFT_BITS-1:0] shifted;
   logic                      ovf;
   sample_type                y_sat;

   assign rd_addr = HIST_ADDR_BITS'(HIST_ADDR_BITS'(ch_ff) * HIST_ADDR_BITS'(NUM_BANDS)
                                   + HIST_ADDR_BITS'(cmd.rd_band));

   always_comb begin
      for (int k = 0; k < COEFS_PER_BAND; k++) begin
         if (coef_row_vld_ff[k]) begin
            coef_eff[k] = coef_row_ff[k];
         end else if (SEL_BITS'(k) == COEF_B0) begin
            coef_eff[k] = COEF_ONE;
         end else begin
            coef_eff[k] = '0;
         end
      end
      hist_eff = hist_row_vld_ff ? hist_row_ff : '0;
   end

   // one product per step: y = b0*x + b1*x1 + b2*x2 - b1*y1 - a2*y2
   always_comb begin
      op_c   = '0;
      op_s   = '0;
      op_sub = 1'b0;
      case (cmd.step)
         STEP_B0_X: begin
            op_c = coef_eff[COEF_B0];
            op_s = x_ff;
         end
         STEP_B1_X1: begin
            op_c = coef_eff[COEF_B1];
            op_s = hist_eff.x1;
         end
         STEP_B2_X2: begin
            op_c = coef_eff[COEF_B2];
            op_s = hist_eff.x2;
         end
         STEP_A1_Y1: begin
            op_c   = coef_eff[COEF_B1];
            op_s   = hist_eff.y1;
            op_sub = 1'b1;
         end
         STEP_A2_Y2: begin
            op_c   = coef_eff[COEF_A2];
            op_s   = hist_eff.y2;
            op_sub = 1'b1;
         end
         default: begin
            op_c = '0;
         end
      endcase
   end

   assign mul = op_c * op_s;

   // round half up, then saturate to the sample width
   assign rnd     = acc_ff + ROUND_HALF;
   assign shifted = rnd[ACC_BITS-1:COEF_FRAC_BITS];
   assign ovf     = !((&shifted[SHIFT_BITS-1:SAMPLE_BITS-1])
                      || !(|shifted[SHIFT_BITS-1:SAMPLE_BITS-1]));
   assign y_sat   = ovf ? (shifted[SHIFT_BITS-1] ? SAMPLE_MIN : SAMPLE_MAX)
                        : shifted[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.coef_wr) begin
         coef_mem[req_band[BAND_IDX_BITS-1:0]][req_coef_select] <= req_coef_value;
      end
      if (cmd.rd_en) begin
         coef_row_ff <= coef_mem[cmd.rd_band];
         hist_row_ff <= hist_mem[rd_addr];
      end
      if (cmd.band_done) begin
         hist_mem[hist_addr_ff] <= '{x1: x_ff, x2: hist_eff.x1, y1: y_sat, y2: hist_eff.y1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff  <= '0;
         hist_vld_ff  <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.coef_wr) begin
            coef_vld_ff[req_band[BAND_IDX_BITS-1:0]][req_coef_select] <= 1'b1;
         end
         if (cmd.band_done) begin
            hist_vld_ff[hist_addr_ff] <= 1'b1;
         end
         prod_vld_ff <= cmd.mul_en;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff    <= req_sample_in;
         ch_ff   <= req_channel;
         clip_ff <= 1'b0;
      end else if (cmd.band_done) begin
         x_ff    <= y_sat;
         clip_ff <= clip_ff | ovf;
      end
      if (cmd.rd_en) begin
         coef_row_vld_ff <= coef_vld_ff[cmd.rd_band];
         hist_row_vld_ff <= hist_vld_ff[rd_addr];
         hist_addr_ff    <= rd_addr;
      end
      prod_ff     <= mul;
      prod_sub_ff <= op_sub;
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= prod_sub_ff ? acc_ff - ACC_BITS'(prod_ff) : acc_ff + ACC_BITS'(prod_ff);
      end
      if (cmd.out_load) begin
         rsp_sample_ff  <= x_ff;
         rsp_channel_ff <= ch_ff;
         rsp_clipped_ff <= clip_ff;
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_clipped     = rsp_clipped_ff;

endmodule

@@ src/graphic_eq_peaking_biquad_cascade.sv @@
// coefficient load beat: taken while idle and leaves the block idle, so ready stays high
// sample beat: ready drops; each band not bypassed is read, run through five products on the
// single shared multiplier, drained and rounded, then the result is loaded into the output
// register, waiting while an earlier result is stalled, and ready returns
// reset (synchronous): all bands bypassed, coefficients read as b0 = 1.0 and the rest
// zero, all filter history zero, no result pending; ready right after reset
module graphic_eq_peaking_biquad_cascade (
   input  logic                         clock,
   input  logic                         reset,
   geq_req_if.sink                      req_if,
   geq_rsp_if.source                    rsp_if,
   input  logic                         csr_wr_en,
   input  logic [geq_pkg::CFG_BITS-1:0] csr_wr_data
);
   import geq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   geq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_mode    (req_if.mode),
      .req_band    (req_if.band),
      .req_ready   (req_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd)
   );

   geq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_channel     (req_if.channel),
      .req_band        (req_if.band),
      .req_coef_select (req_if.coef_select),
      .req_coef_value  (req_if.coef_value),
      .req_sample_in   (req_if.sample_in),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_sample_out  (rsp_if.sample_out),
      .rsp_channel_out (rsp_if.channel_out),
      .rsp_clipped     (rsp_if.clipped)
   );

   assign req_if.ready = req_ready;

endmodule

@@ src/geq_checker.sv @@
`include "graphic_eq_peaking_biquad_cascade_assert.svh"

module geq_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_mode,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input geq_pkg::sample_type rsp_sample_out,
   input logic                rsp_channel_out,
   input logic                rsp_clipped
);
   import geq_pkg::*;

   // a stalled result beat stays up with the same payload
   `GEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `GEQ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_sample_out) && $stable(rsp_channel_out) && $stable(rsp_clipped))

   // a sample occupies the filter, a coefficient load does not
   `GEQ_ASSERT_NEXT(a_sample_busy, clock, reset, req_valid && req_ready && req_mode == MODE_SAMPLE, !req_ready)
   `GEQ_ASSERT_NEXT(a_load_free, clock, reset, req_valid && req_ready && req_mode == MODE_LOAD, req_ready)

endmodule

bind graphic_eq_peaking_biquad_cascade geq_checker u_geq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_mode        (req_if.mode),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_sample_out  (rsp_if.sample_out),
   .rsp_channel_out (rsp_if.channel_out),
   .rsp_clipped     (rsp_if.clipped)
);

@@ tb/tb_graphic_eq_peaking_biquad_cascade.sv @@
`timescale 1ns / 100ps

module tb_graphic_eq_peaking_biquad_cascade;
   import geq_pkg::*;

   localparam int       SETTLE_CYCLES = 100;
   localparam int       PHASE_ITEMS   = 120;
   localparam int       PRINT_LIMIT   = 40;
   localparam coef_type COEF_TOP      = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam coef_type COEF_BOTTOM   = {1'b1, {(COEF_BITS-1){1'b0}}};

   typedef struct packed {
      sample_type sample;
      logic       channel;
      logic       clipped;
   } eq_out_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CFG_BITS-1:0] csr_wr_data;

   geq_req_if req_bus ();
   geq_rsp_if rsp_bus ();

   graphic_eq_peaking_biquad_cascade uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the equalizer state
   coef_type            coef_bank [NUM_BANDS][COEFS_PER_BAND];
   hist_row_type        band_hist [NUM_CHANNELS][NUM_BANDS];
   logic [CFG_BITS-1:0] bypass_bits;

   eq_out_type eq_out_queue[$];

   int mismatch_count;
   int results_seen;
   int clipped_count;
   int sample_count;
   int load_count;
   int mask_writes;
   int burst_left;
   bit gaps_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(string field, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch at result %0d, %s: got %0d, expected %0d",
                  results_seen, field, got, want);
      end
   endtask

   task automatic clear_eq_state();
      for (int b = 0; b < NUM_BANDS; b++) begin
         for (int k = 0; k < COEFS_PER_BAND; k++) begin
            coef_bank[b][k] = (k == COEF_B0) ? COEF_ONE : '0;
         end
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            band_hist[c][b] = '0;
         end
      end
      bypass_bits = '1;
   endtask

   // run one sample through the active bands, updating their history
   function automatic eq_out_type equalize_sample(logic ch, sample_type x_in);
      eq_out_type   r;
      hist_row_type h;
      sample_type   x;
      longint       acc;
      longint       y;
      logic         clip;
      x    = x_in;
      clip = 1'b0;
      for (int b = 0; b < NUM_BANDS; b++) begin
         if (!bypass_bits[b]) begin
            h   = band_hist[ch][b];
            acc = longint'(coef_bank[b][COEF_B0]) * longint'(x)
                + longint'(coef_bank[b][COEF_B1]) * longint'(h.x1)
                + longint'(coef_bank[b][COEF_B2]) * longint'(h.x2)
                - longint'(coef_bank[b][COEF_B1]) * longint'(h.y1)
                - longint'(coef_bank[b][COEF_A2]) * longint'(h.y2);
            // round half up, then floor
            y = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (y > longint'(SAMPLE_MAX)) begin
               y    = longint'(SAMPLE_MAX);
               clip = 1'b1;
            end
            if (y < longint'(SAMPLE_MIN)) begin
               y    = longint'(SAMPLE_MIN);
               clip = 1'b1;
            end
            h.x2 = h.x1;
            h.x1 = x;
            h.y2 = h.y1;
            h.y1 = sample_type'(y);
            band_hist[ch][b] = h;
            x = sample_type'(y);
         end
      end
      r.sample  = x;
      r.channel = ch;
      r.clipped = clip;
      return r;
   endfunction

   task automatic drive_request(logic mode, logic ch, logic [BAND_BITS-1:0] band,
                                logic [SEL_BITS-1:0] sel, coef_type cv, sample_type smp);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= mode;
      req_bus.channel     <= ch;
      req_bus.band        <= band;
      req_bus.coef_select <= sel;
      req_bus.coef_value  <= cv;
      req_bus.sample_in   <= smp;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (mode == MODE_LOAD) begin
         if (band < NUM_BANDS) coef_bank[band][sel] = cv;
         load_count++;
      end else begin
         eq_out_queue.push_back(equalize_sample(ch, smp));
         sample_count++;
      end
      @(negedge clock);
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_bus.valid <= 1'b0;
            gap = ($urandom_range(4, 0) == 0) ? $urandom_range(90, 10) : $urandom_range(5, 1);
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(12, 1);
         end
      end
   endtask

   task automatic send_sample(logic ch, sample_type smp);
      drive_request(MODE_SAMPLE, ch, BAND_BITS'($urandom), SEL_BITS'($urandom),
                    coef_type'($urandom), smp);
   endtask

   task automatic send_load(logic [BAND_BITS-1:0] band, logic [SEL_BITS-1:0] sel,
                            coef_type cv);
      drive_request(MODE_LOAD, 1'($urandom), band, sel, cv, sample_type'($urandom));
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      while (eq_out_queue.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // a trailing load may still be in flight when the last result lands
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (eq_out_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_bypass(logic [CFG_BITS-1:0] mask);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mask;
      @(posedge clock);
      bypass_bits = mask;
      mask_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stable peaking section: unity at dc, boost or cut around a random center
   task automatic load_peaking_band(int band);
      real beta;
      real g2;
      real cw;
      real den;
      beta = $urandom_range(900, 20) / 1000.0;
      g2   = $urandom_range(2000, 250) / 1000.0;
      cw   = ($urandom_range(1980, 0) - 990.0) / 1000.0;
      den  = 1.0 + beta;
      send_load(BAND_BITS'(band), COEF_B0,
                coef_type'($rtoi((1.0 + beta * g2) / den * 4194304.0)));
      send_load(BAND_BITS'(band), COEF_B1,
                coef_type'($rtoi(-2.0 * cw / den * 4194304.0)));
      send_load(BAND_BITS'(band), COEF_B2,
                coef_type'($rtoi((1.0 - beta * g2) / den * 4194304.0)));
      send_load(BAND_BITS'(band), COEF_A2,
                coef_type'($rtoi((1.0 - beta) / den * 4194304.0)));
   endtask

   function automatic sample_type pick_sample();
      int r;
      r = $urandom_range(9, 0);
      if (r == 0) return SAMPLE_MAX;
      if (r == 1) return SAMPLE_MIN;
      if (r < 6) return sample_type'($urandom_range(2**19, 0) - 2**18);
      return sample_type'($urandom);
   endfunction

   // all bands bypassed out of reset; loads to bands past the end are dropped
   task automatic test_reset_state();
      send_sample(1'b0, SAMPLE_MAX);
      send_load(4'd10, COEF_B0, COEF_TOP);
      send_sample(1'b1, SAMPLE_MIN);
      send_load(4'd15, COEF_A2, COEF_BOTTOM);
      send_sample(1'b0, '0);
      send_sample(1'b1, '1);
   endtask

   task automatic test_identity_cascade();
      settle_idle();
      write_bypass('0);
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);
      send_sample(1'b0, sample_type'(1));
   endtask

   task automatic test_coef_extremes();
      send_load(4'd0, COEF_B0, COEF_TOP);
      send_load(4'd3, COEF_B1, COEF_BOTTOM);
      send_load(4'd5, COEF_B2, COEF_TOP);
      send_load(4'd9, COEF_A2, COEF_BOTTOM);
      send_sample(1'b0, sample_type'(1));
      send_sample(1'b0, SAMPLE_MAX);
      send_sample(1'b1, SAMPLE_MIN);
      send_sample(1'b0, '0);
      send_sample(1'b1, '1);
      // history stays frozen while every band is skipped
      settle_idle();
      write_bypass('1);
      send_sample(1'b0, sample_type'(12345));
      settle_idle();
      write_bypass('0);
      send_sample(1'b0, '0);
      send_load(4'd0, COEF_B0, COEF_ONE);
      send_load(4'd3, COEF_B1, '0);
      send_load(4'd5, COEF_B2, '0);
      send_load(4'd9, COEF_A2, '0);
   endtask

   task automatic test_random_filters();
      logic [CFG_BITS-1:0] mask;
      int                  done;
      int                  r;
      int                  b;
      bit                  held;
      held = 1'b0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       mask = '0;
            2:       mask = 10'h155;
            4:       mask = 10'h2aa;
            5:       mask = '1;
            default: mask = CFG_BITS'($urandom);
         endcase
         settle_idle();
         write_bypass(mask);
         gaps_on    = (phase != 2);
         burst_left = $urandom_range(12, 1);
         repeat ($urandom_range(4, 2)) load_peaking_band($urandom_range(NUM_BANDS - 1, 0));
         done = 0;
         while (done < PHASE_ITEMS) begin
            if (phase == 3 && !held && done >= PHASE_ITEMS / 2) begin
               hold_until_drained();
               held = 1'b1;
            end
            r = $urandom_range(99, 0);
            if (r < 76) begin
               send_sample(1'($urandom), pick_sample());
               done++;
            end else if (r < 92) begin
               load_peaking_band($urandom_range(NUM_BANDS - 1, 0));
               done += 4;
            end else begin
               // raw word, often to a band that does not exist
               b = $urandom_range(15, 0);
               if (r < 97) begin
                  send_load(BAND_BITS'(b), SEL_BITS'($urandom), coef_type'($urandom));
               end else begin
                  send_load(BAND_BITS'(b), SEL_BITS'($urandom),
                            (r & 1) ? COEF_TOP : COEF_BOTTOM);
               end
               if (b < NUM_BANDS) done++;
            end
         end
      end
   endtask

   initial begin : rsp_stall_pattern
      int stall_kind;
      int stall_left;
      stall_kind = 0;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) begin
            stall_kind = $urandom_range(3, 0);
            stall_left = $urandom_range(256, 32);
         end
         stall_left--;
         case (stall_kind)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom);
            2:       rsp_bus.ready <= ($urandom_range(3, 0) == 0);
            default: rsp_bus.ready <= ~rsp_bus.ready;
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      eq_out_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (eq_out_queue.size() == 0) begin
            report_mismatch("beat with nothing pending", longint'(rsp_bus.sample_out), 0);
         end else begin
            want = eq_out_queue.pop_front();
            if (want.clipped) clipped_count++;
            if (rsp_bus.sample_out !== want.sample) begin
               report_mismatch("sample_out", longint'(rsp_bus.sample_out),
                               longint'(want.sample));
            end
            if (rsp_bus.channel_out !== want.channel) begin
               report_mismatch("channel_out", longint'(rsp_bus.channel_out),
                               longint'(want.channel));
            end
            if (rsp_bus.clipped !== want.clipped) begin
               report_mismatch("clipped", longint'(rsp_bus.clipped),
                               longint'(want.clipped));
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      results_seen   = 0;
      clipped_count  = 0;
      sample_count   = 0;
      load_count     = 0;
      mask_writes    = 0;
      gaps_on        = 1'b1;
      burst_left     = 4;
      clear_eq_state();
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= MODE_SAMPLE;
      req_bus.channel     <= 1'b0;
      req_bus.band        <= '0;
      req_bus.coef_select <= COEF_B0;
      req_bus.coef_value  <= '0;
      req_bus.sample_in   <= '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_identity_cascade();
      test_coef_extremes();
      test_random_filters();
      settle_idle();

      $display("covered %0d samples (%0d clipped) and %0d coefficient loads",
               sample_count, clipped_count, load_count);
      $display("across %0d bypass settings; %0d results checked, %0d mismatches",
               mask_writes, results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/geq_pkg.sv
src/geq_req_if.sv
src/geq_rsp_if.sv
src/geq_ctrl.sv
src/geq_dp.sv
src/graphic_eq_peaking_biquad_cascade.sv
src/geq_checker.sv
tb/tb_graphic_eq_peaking_biquad_cascade.sv
